>>> hdl/wlq_pkg.sv
// Package: widths, payload structs and helpers for the wide line quad expansion.
`default_nettype none
package wlq_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 4;
  localparam int WW         = 12;
  localparam int COLOR_BITS = 32;
  localparam int DW         = COORD_BITS + 1;
  localparam int AW         = COORD_BITS;
  localparam int SW         = 2 * AW + 1;
  localparam int MW         = AW + WW;
  localparam int PW         = 2 * MW;
  localparam int NB         = WW;
  localparam int TW         = NB + 1;
  localparam int RW         = TW + SW + 1;
  localparam int QW         = 2 * TW + SW + 1;
  localparam int NV         = 6;
  localparam int CNTW       = 3;
  localparam logic [CNTW-1:0] VTX_LAST = CNTW'(NV - 1);
  localparam logic [CNTW-1:0] VTX_4    = CNTW'(4);
  localparam logic [WW-1:0]   THIN_MAX = WW'(1) << FRAC_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t                x0;
    coord_t                y0;
    coord_t                x1;
    coord_t                y1;
    coord_t                mx;
    coord_t                my;
    logic [WW-1:0]         w;
    logic [COLOR_BITS-1:0] color;
    logic                  thin;
    logic                  zero;
    logic                  dx_neg;
    logic                  dy_pos;
  } seg_t;

  typedef struct packed {
    logic [NB-1:0]        n;
    logic signed [QW-1:0] q;
    logic signed [RW-1:0] r;
  } lane_t;

  typedef struct packed {
    logic [SW-1:0] s;
    logic [PW-1:0] px;
    logic [PW-1:0] py;
  } cmp_t;

  function automatic coord_t sat_coord(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = DW'({1'b0, {(COORD_BITS-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

>>> hdl/wide_line_quad_expansion.sv
// Top level: line segment to six triangle vertices, pipelined exact offset search.
//
// One segment word is taken per cycle, unless the sequencer stalls the whole
// pipeline, into NB + 4 (16) stages: a front stage for differences and
// midpoint, two multiply stages, one stage per bit of the rounded offset
// magnitude (shift-add square compare, both axes in parallel) and a corner
// stage with saturation. The corner stage feeds a sequencer that sends one
// vertex word per cycle while out_ready allows, six for each segment; the
// pipeline takes no new segment until the last vertex is sent. A wide
// segment of zero length leaves the corner stage and sends no vertex.
`default_nettype none
module wide_line_quad_expansion (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [wlq_pkg::COORD_BITS-1:0] in_start_x,
  input  wire logic signed [wlq_pkg::COORD_BITS-1:0] in_start_y,
  input  wire logic signed [wlq_pkg::COORD_BITS-1:0] in_end_x,
  input  wire logic signed [wlq_pkg::COORD_BITS-1:0] in_end_y,
  input  wire logic [wlq_pkg::WW-1:0]          in_line_width,
  input  wire logic [wlq_pkg::COLOR_BITS-1:0]  in_rgba,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [wlq_pkg::COORD_BITS-1:0] out_vert_x,
  output logic signed [wlq_pkg::COORD_BITS-1:0] out_vert_y,
  output logic [wlq_pkg::COLOR_BITS-1:0]       out_vert_color,
  output logic                                 out_final_vertex
);
  import wlq_pkg::*;

  logic adv;

  // front stage
  logic signed [DW-1:0] dx, dy, sx, sy;
  logic [AW-1:0] adx, ady;
  seg_t seg_in;
  seg_t seg_a_r;
  logic [AW-1:0] adx_a_r, ady_a_r;
  logic va_r;

  always_comb begin
    dx = DW'(in_end_x) - DW'(in_start_x);
    dy = DW'(in_end_y) - DW'(in_start_y);
    sx = DW'(in_end_x) + DW'(in_start_x);
    sy = DW'(in_end_y) + DW'(in_start_y);
    adx = dx[DW-1] ? AW'(-dx) : AW'(dx);
    ady = dy[DW-1] ? AW'(-dy) : AW'(dy);
    seg_in.x0 = in_start_x;
    seg_in.y0 = in_start_y;
    seg_in.x1 = in_end_x;
    seg_in.y1 = in_end_y;
    seg_in.mx = sx[DW-1:1];
    seg_in.my = sy[DW-1:1];
    seg_in.w = in_line_width;
    seg_in.color = in_rgba;
    seg_in.thin = (in_line_width <= THIN_MAX);
    seg_in.zero = (dx == '0) && (dy == '0);
    seg_in.dx_neg = dx[DW-1];
    seg_in.dy_pos = !dy[DW-1] && (dy != '0);
  end

  // multiply stages
  seg_t seg_b_r;
  logic [2*AW-1:0] sqx_b_r, sqy_b_r;
  logic [MW-1:0] mwx_b_r, mwy_b_r;
  logic vb_r;

  seg_t  seg_s_r [NB+1];
  lane_t lx_r [NB+1];
  lane_t ly_r [NB+1];
  cmp_t  cmp_r [NB+1];
  logic  vs_r [NB+1];

  logic [SW-1:0] s_c;
  always_comb begin
    s_c = SW'(sqx_b_r) + SW'(sqy_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vs_r[0] <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vs_r[0] <= vb_r;
    end
    if (adv) begin
      seg_a_r <= seg_in;
      adx_a_r <= adx;
      ady_a_r <= ady;
      seg_b_r <= seg_a_r;
      sqx_b_r <= adx_a_r * adx_a_r;
      sqy_b_r <= ady_a_r * ady_a_r;
      mwx_b_r <= MW'(ady_a_r) * MW'(seg_a_r.w);
      mwy_b_r <= MW'(adx_a_r) * MW'(seg_a_r.w);
      seg_s_r[0] <= seg_b_r;
      cmp_r[0].s <= s_c;
      cmp_r[0].px <= PW'(mwx_b_r) * PW'(mwx_b_r);
      cmp_r[0].py <= PW'(mwy_b_r) * PW'(mwy_b_r);
      lx_r[0].n <= '0;
      lx_r[0].q <= QW'(s_c);
      lx_r[0].r <= -RW'(s_c);
      ly_r[0].n <= '0;
      ly_r[0].q <= QW'(s_c);
      ly_r[0].r <= -RW'(s_c);
    end
  end

  // offset search, one magnitude bit per stage, MSB first
  for (genvar i = 0; i < NB; i++) begin : g_srch
    localparam int K = NB - 1 - i;
    lane_t nx, ny;
    logic signed [QW-1:0] s_q;
    logic signed [RW-1:0] s_r;

    function automatic lane_t try_bit(input lane_t l, input logic [PW-1:0] p,
                                      input logic signed [QW-1:0] sq,
                                      input logic signed [RW-1:0] sr,
                                      input logic [WW-1:0] w);
      lane_t c;
      logic signed [QW-1:0] rq;
      rq = {{(QW-RW){l.r[RW-1]}}, l.r};
      c.n = l.n | (NB'(1) << K);
      c.q = l.q + (rq <<< (K + 2)) + (sq <<< (2 * K + 2));
      c.r = l.r + (sr <<< (K + 1));
      if (({c.n, 1'b0} <= ({1'b0, w} + (WW+1)'(1))) && (c.q <= $signed(QW'(p)))) begin
        return c;
      end
      return l;
    endfunction

    always_comb begin
      s_q = QW'(cmp_r[i].s);
      s_r = RW'(cmp_r[i].s);
      nx = try_bit(lx_r[i], cmp_r[i].px, s_q, s_r, seg_s_r[i].w);
      ny = try_bit(ly_r[i], cmp_r[i].py, s_q, s_r, seg_s_r[i].w);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[i+1] <= 1'b0;
      end else if (adv) begin
        vs_r[i+1] <= vs_r[i];
      end
      if (adv) begin
        seg_s_r[i+1] <= seg_s_r[i];
        cmp_r[i+1] <= cmp_r[i];
        lx_r[i+1] <= nx;
        ly_r[i+1] <= ny;
      end
    end
  end

  // corner stage
  seg_t sg;
  logic signed [DW-1:0] ox, oy;
  coord_t cx [4];
  coord_t cy [4];
  coord_t hx_r [4];
  coord_t hy_r [4];
  logic [COLOR_BITS-1:0] hcolor_r;
  logic hthin_r, hzero_r, hv_r;

  always_comb begin
    sg = seg_s_r[NB];
    ox = sg.dy_pos ? -DW'(lx_r[NB].n) : DW'(lx_r[NB].n);
    oy = sg.dx_neg ? -DW'(ly_r[NB].n) : DW'(ly_r[NB].n);
    if (sg.thin) begin
      cx[0] = sg.x0; cy[0] = sg.y0;
      cx[1] = sg.x1; cy[1] = sg.y1;
      cx[2] = sg.mx; cy[2] = sg.my;
      cx[3] = sg.mx; cy[3] = sg.my;
    end else begin
      cx[0] = sat_coord(DW'(sg.x0) + ox); cy[0] = sat_coord(DW'(sg.y0) + oy);
      cx[1] = sat_coord(DW'(sg.x0) - ox); cy[1] = sat_coord(DW'(sg.y0) - oy);
      cx[2] = sat_coord(DW'(sg.x1) - ox); cy[2] = sat_coord(DW'(sg.y1) - oy);
      cx[3] = sat_coord(DW'(sg.x1) + ox); cy[3] = sat_coord(DW'(sg.y1) + oy);
    end
  end

  // vertex sequencer
  logic [CNTW-1:0] cnt_r;
  logic [1:0] sel;
  logic emit, drop, h_done;

  always_comb begin
    emit = hv_r && !hzero_r && (!out_valid || out_ready);
    drop = hv_r && hzero_r;
    h_done = drop || (emit && (cnt_r == VTX_LAST));
    adv = !hv_r || h_done;
    in_ready = adv;
    case (cnt_r)
      3'd0: sel = 2'd0;
      3'd1: sel = 2'd1;
      3'd2: sel = 2'd2;
      3'd3: sel = 2'd0;
      VTX_4: sel = hthin_r ? 2'd1 : 2'd2;
      default: sel = 2'd3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        hv_r <= vs_r[NB];
      end
      if (emit) begin
        out_valid <= 1'b1;
        cnt_r <= (cnt_r == VTX_LAST) ? '0 : cnt_r + CNTW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (adv) begin
      hx_r <= cx;
      hy_r <= cy;
      hcolor_r <= sg.color;
      hthin_r <= sg.thin;
      hzero_r <= sg.zero && !sg.thin;
    end
    if (emit) begin
      out_vert_x <= hx_r[sel];
      out_vert_y <= hy_r[sel];
      out_vert_color <= hcolor_r;
      out_final_vertex <= (cnt_r == VTX_LAST);
    end
  end
endmodule
`default_nettype wire
